// File: hw/rtl/mta_pkg.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager package
// Shared widths, register indexes and the tile record passed front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package mta_pkg;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 22;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int AREA_W     = 16;
  localparam int TS_CFG_W   = 7;
  localparam int RW_CFG_W   = 12;
  localparam int RH_CFG_W   = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_REGION_HEIGHT = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd2;

  localparam logic [TS_CFG_W-1:0] TILE_SIZE_RST     = 7'd5;
  localparam logic [RW_CFG_W-1:0] REGION_WIDTH_RST  = 12'd640;
  localparam logic [RH_CFG_W-1:0] REGION_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [ROW_W-1:0]  tile_row;
    logic [COL_W-1:0]  tile_column;
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [AREA_W-1:0] area;
    logic              final_tile;
  } tile_t;

endpackage

`default_nettype wire

// File: hw/rtl/mta_front.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager front end
// Holds configuration and raster position, accumulates per tile column sums
// in a memory and hands each completed tile to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mta_front #(
  parameter int MAX_REGION_WIDTH = 2048,
  parameter int MAX_TILE_SIZE    = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mta_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          acc,
  input  wire logic [mta_pkg::CH_W-1:0]      pixel_red,
  input  wire logic [mta_pkg::CH_W-1:0]      pixel_green,
  input  wire logic [mta_pkg::CH_W-1:0]      pixel_blue,
  input  wire logic                          frame_start,
  output logic                               busy,
  output logic                               push,
  output mta_pkg::tile_t                     push_data
);

  localparam int CW  = $clog2(MAX_REGION_WIDTH);
  localparam int CW1 = CW + 1;
  localparam int TW  = $clog2(MAX_TILE_SIZE + 1);
  localparam int RW  = mta_pkg::ROW_W;
  localparam int RW1 = RW + 1;
  localparam int DW  = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int NW  = $clog2(DW + 1);
  localparam int SW  = mta_pkg::SUM_W;
  localparam int MW  = 3 * SW;

  localparam logic [1:0] CALC_COL  = 2'd0;
  localparam logic [1:0] CALC_ROW  = 2'd1;
  localparam logic [1:0] CALC_WID  = 2'd2;
  localparam logic [1:0] CALC_HGT  = 2'd3;

  logic [mta_pkg::TS_CFG_W-1:0] ts_cfg_r;
  logic [mta_pkg::RW_CFG_W-1:0] w_cfg_r;
  logic [mta_pkg::RH_CFG_W-1:0] h_cfg_r;
  logic [TW-1:0] ts_eff, ts_m1;
  logic [DW-1:0] w_eff, h_eff;

  logic [CW-1:0]  col_r, tc_r;
  logic [RW-1:0]  row_r, tr_r;
  logic [TW-1:0]  offx_r, offy_r, colmod_r, rowmod_r;
  logic [CW1-1:0] fcols_r;
  logic [RW1-1:0] frows_r;

  logic          calc_r, ld_r;
  logic [1:0]    sel_r;
  logic [NW-1:0] cnt_r;
  logic [DW-1:0] dvd_r, quo_r, quo_nx, dvd_src;
  logic [TW-1:0] rem_r, rem_nx;
  logic [TW:0]   trial;
  logic          ge;

  logic [CW-1:0] cur_col, cur_tc;
  logic [RW-1:0] cur_row, cur_tr;
  logic [TW-1:0] cur_offx, cur_offy, cur_colmod, cur_rowmod;
  logic          hit, first, last, fin;

  logic [CW-1:0] col_nxt, tc_nxt;
  logic [RW-1:0] row_nxt, tr_nxt;
  logic [TW-1:0] offx_nxt, offy_nxt, colmod_nxt, rowmod_nxt;

  logic [MW-1:0] mem [MAX_REGION_WIDTH];
  logic [MW-1:0] rd_r;
  logic          s1_v_r, s1_first_r, s1_last_r, s1_final_r;
  logic [CW-1:0] s1_addr_r;
  logic [RW-1:0] s1_tr_r;
  logic [mta_pkg::CH_W-1:0] s1_r_r, s1_g_r, s1_b_r;
  logic          fw_v_r;
  logic [CW-1:0] fw_addr_r;
  logic [MW-1:0] fw_data_r;
  logic [MW-1:0] base, wdata;

  // Out of range settings behave as the nearest legal value.
  always_comb begin
    if (ts_cfg_r == '0) ts_eff = TW'(1);
    else if (ts_cfg_r > MAX_TILE_SIZE) ts_eff = TW'(MAX_TILE_SIZE);
    else ts_eff = TW'(ts_cfg_r);
    if (w_cfg_r == '0) w_eff = DW'(1);
    else if (w_cfg_r > MAX_REGION_WIDTH) w_eff = DW'(MAX_REGION_WIDTH);
    else w_eff = DW'(w_cfg_r);
    if (h_cfg_r == '0) h_eff = DW'(1);
    else if (h_cfg_r > mta_pkg::MAX_REGION_HEIGHT) h_eff = DW'(mta_pkg::MAX_REGION_HEIGHT);
    else h_eff = DW'(h_cfg_r);
    ts_m1 = ts_eff - 1'b1;
  end

  // Shared restoring divider: rebuilds the tile indexes, the offsets inside a
  // tile and the full tile counts whenever the settings change.
  always_comb begin
    unique case (sel_r)
      CALC_COL: dvd_src = DW'(col_r);
      CALC_ROW: dvd_src = DW'(row_r);
      CALC_WID: dvd_src = w_eff;
      CALC_HGT: dvd_src = h_eff;
    endcase
    trial  = {rem_r, dvd_r[DW-1]};
    ge     = trial >= {1'b0, ts_eff};
    rem_nx = ge ? TW'(trial - {1'b0, ts_eff}) : trial[TW-1:0];
    quo_nx = {quo_r[DW-2:0], ge};
  end

  assign busy = calc_r;

  always_comb begin
    if (frame_start) begin
      cur_col = '0; cur_row = '0; cur_offx = '0; cur_offy = '0;
      cur_colmod = '0; cur_rowmod = '0; cur_tc = '0; cur_tr = '0;
    end else begin
      cur_col = col_r; cur_row = row_r; cur_offx = offx_r; cur_offy = offy_r;
      cur_colmod = colmod_r; cur_rowmod = rowmod_r; cur_tc = tc_r; cur_tr = tr_r;
    end
    hit   = ({1'b0, cur_tc} < fcols_r) && ({1'b0, cur_tr} < frows_r);
    first = (cur_offx == '0) && (cur_offy == '0);
    last  = (cur_offx == ts_m1) && (cur_offy == ts_m1);
    fin   = ({1'b0, cur_tr} == frows_r - 1'b1) && ({1'b0, cur_tc} == fcols_r - 1'b1);

    offx_nxt = ({1'b0, cur_offx} + 1'b1 >= {1'b0, ts_eff}) ? '0 : cur_offx + 1'b1;
    offy_nxt = cur_offy;
    row_nxt = cur_row; tr_nxt = cur_tr; rowmod_nxt = cur_rowmod;
    if (DW'(cur_col) + 1'b1 >= w_eff) begin
      col_nxt = '0; tc_nxt = '0; colmod_nxt = '0; offx_nxt = '0;
      offy_nxt = ({1'b0, cur_offy} + 1'b1 >= {1'b0, ts_eff}) ? '0 : cur_offy + 1'b1;
      if (DW'(cur_row) + 1'b1 >= h_eff) begin
        row_nxt = '0; tr_nxt = '0; rowmod_nxt = '0; offy_nxt = '0;
      end else begin
        row_nxt = cur_row + 1'b1;
        if (cur_rowmod == ts_m1) begin
          rowmod_nxt = '0; tr_nxt = cur_tr + 1'b1;
        end else begin
          rowmod_nxt = cur_rowmod + 1'b1;
        end
      end
    end else begin
      col_nxt = cur_col + 1'b1;
      if (cur_colmod == ts_m1) begin
        colmod_nxt = '0; tc_nxt = cur_tc + 1'b1;
      end else begin
        colmod_nxt = cur_colmod + 1'b1; tc_nxt = cur_tc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_cfg_r <= mta_pkg::TILE_SIZE_RST;
      w_cfg_r  <= mta_pkg::REGION_WIDTH_RST;
      h_cfg_r  <= mta_pkg::REGION_HEIGHT_RST;
      col_r <= '0; row_r <= '0; offx_r <= '0; offy_r <= '0;
      colmod_r <= '0; rowmod_r <= '0; tc_r <= '0; tr_r <= '0;
      fcols_r <= '0; frows_r <= '0;
      calc_r <= 1'b1; ld_r <= 1'b1; sel_r <= CALC_COL; cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mta_pkg::CFG_TILE_SIZE:     ts_cfg_r <= cfg_wdata[mta_pkg::TS_CFG_W-1:0];
        mta_pkg::CFG_REGION_WIDTH:  w_cfg_r  <= cfg_wdata[mta_pkg::RW_CFG_W-1:0];
        mta_pkg::CFG_REGION_HEIGHT: h_cfg_r  <= cfg_wdata[mta_pkg::RH_CFG_W-1:0];
        default: ;
      endcase
      calc_r <= 1'b1; ld_r <= 1'b1; sel_r <= CALC_COL;
    end else if (calc_r) begin
      if (ld_r) begin
        ld_r <= 1'b0; dvd_r <= dvd_src; rem_r <= '0; quo_r <= '0; cnt_r <= NW'(DW);
      end else begin
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        rem_r <= rem_nx; quo_r <= quo_nx; cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          ld_r  <= 1'b1;
          sel_r <= sel_r + 1'b1;
          unique case (sel_r)
            CALC_COL: begin tc_r <= CW'(quo_nx); colmod_r <= rem_nx; end
            CALC_ROW: begin tr_r <= RW'(quo_nx); rowmod_r <= rem_nx; end
            CALC_WID: fcols_r <= CW1'(quo_nx);
            CALC_HGT: begin frows_r <= RW1'(quo_nx); calc_r <= 1'b0; end
          endcase
        end
      end
    end else if (acc) begin
      col_r <= col_nxt; row_r <= row_nxt; offx_r <= offx_nxt; offy_r <= offy_nxt;
      colmod_r <= colmod_nxt; rowmod_r <= rowmod_nxt; tc_r <= tc_nxt; tr_r <= tr_nxt;
    end
  end

  // Accumulate stage: the sum read at the accepting edge is completed and
  // written back in the cycle after. A write on the edge of that read is forwarded.
  always_comb begin
    if (s1_first_r) base = '0;
    else if (fw_v_r && (fw_addr_r == s1_addr_r)) base = fw_data_r;
    else base = rd_r;
    wdata[3*SW-1:2*SW] = base[3*SW-1:2*SW] + SW'(s1_r_r);
    wdata[2*SW-1:SW]   = base[2*SW-1:SW]   + SW'(s1_g_r);
    wdata[SW-1:0]      = base[SW-1:0]      + SW'(s1_b_r);
  end

  always_ff @(posedge clk) begin
    if (acc && hit) rd_r <= mem[cur_tc];
    if (s1_v_r) mem[s1_addr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && hit;
      fw_v_r <= s1_v_r;
    end
    if (acc && hit) begin
      s1_addr_r <= cur_tc; s1_tr_r <= cur_tr;
      s1_first_r <= first; s1_last_r <= last; s1_final_r <= fin;
      s1_r_r <= pixel_red; s1_g_r <= pixel_green; s1_b_r <= pixel_blue;
    end
    fw_addr_r <= s1_addr_r;
    fw_data_r <= wdata;
  end

  assign push = s1_v_r && s1_last_r;

  always_comb begin
    push_data.tile_row    = s1_tr_r;
    push_data.tile_column = mta_pkg::COL_W'(s1_addr_r);
    push_data.sum_red     = wdata[3*SW-1:2*SW];
    push_data.sum_green   = wdata[2*SW-1:SW];
    push_data.sum_blue    = wdata[SW-1:0];
    push_data.area        = mta_pkg::AREA_W'(ts_eff) * mta_pkg::AREA_W'(ts_eff);
    push_data.final_tile  = s1_final_r;
  end

endmodule

`default_nettype wire

// File: hw/rtl/mta_queue.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager tile queue
// Short first-in first-out buffer of completed tile records.
// ---------------------------------------------------------------------------
`default_nettype none

module mta_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mta_pkg::tile_t push_data,
  input  wire logic           pop,
  output mta_pkg::tile_t      pop_data,
  output logic [$clog2(mta_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(mta_pkg::QUEUE_DEPTH);
  localparam int CNW = $clog2(mta_pkg::QUEUE_DEPTH + 1);

  mta_pkg::tile_t q_r [mta_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CNW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) q_r[wp_r] <= push_data;
  end

  assign pop_data = q_r[rp_r];
  assign count    = cnt_r;

endmodule

`default_nettype wire

// File: hw/rtl/mta_back.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager back end
// Divides each tile's three sums by the tile area, one quotient bit per
// cycle, and holds the result until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module mta_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       avail,
  input  wire mta_pkg::tile_t             pop_data,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mta_pkg::ROW_W-1:0]       out_tile_row,
  output logic [mta_pkg::COL_W-1:0]       out_tile_column,
  output logic [mta_pkg::CH_W-1:0]        out_average_red,
  output logic [mta_pkg::CH_W-1:0]        out_average_green,
  output logic [mta_pkg::CH_W-1:0]        out_average_blue,
  output logic                            out_final_tile
);

  localparam int SW  = mta_pkg::SUM_W;
  localparam int DVW = mta_pkg::AREA_W + 8;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]     st_r;
  logic [3:0]     cnt_r;
  logic [SW-1:0]  rem_r [3];
  logic [8:0]     q_r [3];
  logic [SW-1:0]  rem_nx [3];
  logic [8:0]     q_nx [3];
  logic [DVW-1:0] dvs_r;
  logic [mta_pkg::CH_W-1:0] avg_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (DVW'(rem_r[c]) >= dvs_r) begin
        rem_nx[c] = rem_r[c] - SW'(dvs_r);
        q_nx[c]   = {q_r[c][7:0], 1'b1};
      end else begin
        rem_nx[c] = rem_r[c];
        q_nx[c]   = {q_r[c][7:0], 1'b0};
      end
    end
  end

  assign pop = (st_r == B_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      unique case (st_r)
        B_IDLE: if (avail) st_r <= B_DIV;
        B_DIV:  if (cnt_r == 4'd0) st_r <= B_OUT;
        B_OUT:  if (!out_stall) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
    if (pop) begin
      rem_r[0] <= pop_data.sum_red;
      rem_r[1] <= pop_data.sum_green;
      rem_r[2] <= pop_data.sum_blue;
      for (int c = 0; c < 3; c++) q_r[c] <= '0;
      dvs_r <= {pop_data.area, 8'd0};
      cnt_r <= 4'd8;
      out_tile_row    <= pop_data.tile_row;
      out_tile_column <= pop_data.tile_column;
      out_final_tile  <= pop_data.final_tile;
    end else if (st_r == B_DIV) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= rem_nx[c];
        q_r[c]   <= q_nx[c];
        // A quotient of 256 or more saturates.
        if (cnt_r == 4'd0) avg_r[c] <= q_nx[c][8] ? 8'hFF : q_nx[c][7:0];
      end
      dvs_r <= dvs_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign out_valid         = (st_r == B_OUT);
  assign out_average_red   = avg_r[0];
  assign out_average_green = avg_r[1];
  assign out_average_blue  = avg_r[2];

endmodule

`default_nettype wire

// File: hw/rtl/mosaic_tile_averager_unit.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager
// Block averages a raster region into square tiles and reports each full
// tile's channel means with its coordinates.
// ---------------------------------------------------------------------------
// Pixels are taken one per clock in raster order while the four entry tile
// queue has room and the front end is not busy; a full tile then passes
// through the back end as a queue read, nine steps of the shared bit serial
// divider and one output beat, and the back end takes the next tile only
// once that result has been taken. After reset and after every
// configuration write the front end rebuilds its tile indexes with a
// shared restoring divider, four divisions in turn, during which in_stall
// stays high; it is also high in the cycle of the write itself.
`default_nettype none

module mosaic_tile_averager_unit #(
  parameter int MAX_REGION_WIDTH = 2048,
  parameter int MAX_TILE_SIZE    = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mta_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mta_pkg::CH_W-1:0]      in_pixel_red,
  input  wire logic [mta_pkg::CH_W-1:0]      in_pixel_green,
  input  wire logic [mta_pkg::CH_W-1:0]      in_pixel_blue,
  input  wire logic                          in_frame_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mta_pkg::ROW_W-1:0]          out_tile_row,
  output logic [mta_pkg::COL_W-1:0]          out_tile_column,
  output logic [mta_pkg::CH_W-1:0]           out_average_red,
  output logic [mta_pkg::CH_W-1:0]           out_average_green,
  output logic [mta_pkg::CH_W-1:0]           out_average_blue,
  output logic                               out_final_tile
);

  localparam int CNW = $clog2(mta_pkg::QUEUE_DEPTH + 1);

  logic           busy, acc, push, pop;
  mta_pkg::tile_t push_data, pop_data;
  logic [CNW-1:0] q_count;

  // One slot is kept free for the beat still in the accumulate stage.
  assign in_stall = busy || cfg_wr_en ||
                    (q_count >= CNW'(mta_pkg::QUEUE_DEPTH - 1));
  assign acc      = in_valid && !in_stall;

  mta_front #(
    .MAX_REGION_WIDTH (MAX_REGION_WIDTH),
    .MAX_TILE_SIZE    (MAX_TILE_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .pixel_red   (in_pixel_red),
    .pixel_green (in_pixel_green),
    .pixel_blue  (in_pixel_blue),
    .frame_start (in_frame_start),
    .busy        (busy),
    .push        (push),
    .push_data   (push_data)
  );

  mta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  mta_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .avail             (q_count != '0),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tile_row      (out_tile_row),
    .out_tile_column   (out_tile_column),
    .out_average_red   (out_average_red),
    .out_average_green (out_average_green),
    .out_average_blue  (out_average_blue),
    .out_final_tile    (out_final_tile)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mta_checker.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager port checker
// Watches the top level ports for handshake and settling behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

module mta_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          cfg_wr_en,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mta_pkg::ROW_W-1:0]     out_tile_row,
  input wire logic [mta_pkg::COL_W-1:0]     out_tile_column,
  input wire logic [mta_pkg::CH_W-1:0]      out_average_red,
  input wire logic [mta_pkg::CH_W-1:0]      out_average_green,
  input wire logic [mta_pkg::CH_W-1:0]      out_average_blue,
  input wire logic                          out_final_tile
);

  // A result beat held back stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_tile_row, out_tile_column,
      out_average_red, out_average_green, out_average_blue, out_final_tile}))
    else $error("result beat changed while stalled");

  // The tile index rebuild after reset must hold off the input.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken straight after reset");

  // Likewise after any configuration write.
  a_cfg_busy: assert property (@(posedge clk) cfg_wr_en |=> in_stall)
    else $error("input taken straight after a configuration write");

endmodule

bind mosaic_tile_averager_unit mta_checker u_mta_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Mosaic tile averager testbench
// Streams raster pixels through the tile averager under several tile and
// region settings. A local predictor tracks the running sums and emits the
// expected tile averages, which are checked beat by beat against the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_W        = 2048;
  localparam int MAX_TS       = 100;
  localparam int SETTLE_CYC   = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRESS_PHASE  = 3;
  localparam int PRESS_CYC    = 400;

  typedef struct packed {
    logic [mta_pkg::CH_W-1:0] red;
    logic [mta_pkg::CH_W-1:0] green;
    logic [mta_pkg::CH_W-1:0] blue;
    logic                     frame_start;
  } pixel_t;

  typedef struct packed {
    logic [mta_pkg::ROW_W-1:0] tile_row;
    logic [mta_pkg::COL_W-1:0] tile_column;
    logic [mta_pkg::CH_W-1:0]  avg_red;
    logic [mta_pkg::CH_W-1:0]  avg_green;
    logic [mta_pkg::CH_W-1:0]  avg_blue;
    logic                      final_tile;
  } tile_avg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [mta_pkg::CFG_IDX_W-1:0] cfg_index = mta_pkg::CFG_TILE_SIZE;
  logic [mta_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mta_pkg::CH_W-1:0] in_pixel_red = '0;
  logic [mta_pkg::CH_W-1:0] in_pixel_green = '0;
  logic [mta_pkg::CH_W-1:0] in_pixel_blue = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mta_pkg::ROW_W-1:0] out_tile_row;
  logic [mta_pkg::COL_W-1:0] out_tile_column;
  logic [mta_pkg::CH_W-1:0] out_average_red;
  logic [mta_pkg::CH_W-1:0] out_average_green;
  logic [mta_pkg::CH_W-1:0] out_average_blue;
  logic out_final_tile;

  mosaic_tile_averager_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_red(in_pixel_red), .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tile_row(out_tile_row), .out_tile_column(out_tile_column),
    .out_average_red(out_average_red), .out_average_green(out_average_green),
    .out_average_blue(out_average_blue), .out_final_tile(out_final_tile)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [mta_pkg::TS_CFG_W-1:0] tile_size_reg = mta_pkg::TILE_SIZE_RST;
  logic [mta_pkg::RW_CFG_W-1:0] region_width_reg = mta_pkg::REGION_WIDTH_RST;
  logic [mta_pkg::RH_CFG_W-1:0] region_height_reg = mta_pkg::REGION_HEIGHT_RST;
  logic [mta_pkg::SUM_W-1:0] red_acc [MAX_W];
  logic [mta_pkg::SUM_W-1:0] green_acc [MAX_W];
  logic [mta_pkg::SUM_W-1:0] blue_acc [MAX_W];
  int pos_col = 0, pos_row = 0, off_x = 0, off_y = 0;

  pixel_t    pixel_q[$];
  tile_avg_t tile_avg_q[$];
  pixel_t    cur_pixel;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int sender_idle_pct = 0, receiver_stall_pct = 0;
  int phase_no = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int pixels_sent = 0;

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [mta_pkg::CH_W-1:0] mean_of(logic [mta_pkg::SUM_W-1:0] sum,
                                                       int area);
    int a;
    a = int'(sum) / area;
    return (a > 255) ? 8'd255 : a[mta_pkg::CH_W-1:0];
  endfunction

  function automatic void accumulate_pixel(pixel_t p);
    int ts, w, h, full_cols, full_rows, tc, tr;
    tile_avg_t t;
    ts = clamp_to(int'(tile_size_reg), MAX_TS);
    w = clamp_to(int'(region_width_reg), MAX_W);
    h = clamp_to(int'(region_height_reg), mta_pkg::MAX_REGION_HEIGHT);
    full_cols = w / ts;
    full_rows = h / ts;
    if (p.frame_start) begin
      pos_col = 0; pos_row = 0; off_x = 0; off_y = 0;
    end
    tc = pos_col / ts;
    tr = pos_row / ts;
    if (tc < full_cols && tr < full_rows) begin
      if (off_x == 0 && off_y == 0) begin
        red_acc[tc] = mta_pkg::SUM_W'(p.red);
        green_acc[tc] = mta_pkg::SUM_W'(p.green);
        blue_acc[tc] = mta_pkg::SUM_W'(p.blue);
      end else begin
        red_acc[tc] = red_acc[tc] + mta_pkg::SUM_W'(p.red);
        green_acc[tc] = green_acc[tc] + mta_pkg::SUM_W'(p.green);
        blue_acc[tc] = blue_acc[tc] + mta_pkg::SUM_W'(p.blue);
      end
      if (off_x == ts - 1 && off_y == ts - 1) begin
        t.tile_row = tr[mta_pkg::ROW_W-1:0];
        t.tile_column = tc[mta_pkg::COL_W-1:0];
        t.avg_red = mean_of(red_acc[tc], ts * ts);
        t.avg_green = mean_of(green_acc[tc], ts * ts);
        t.avg_blue = mean_of(blue_acc[tc], ts * ts);
        t.final_tile = (tr == full_rows - 1) && (tc == full_cols - 1);
        tile_avg_q.insert(tile_avg_q.size(), t);
      end
    end
    off_x = (off_x + 1 >= ts) ? 0 : off_x + 1;
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      off_x = 0;
      off_y = (off_y + 1 >= ts) ? 0 : off_y + 1;
      if (pos_row + 1 >= h) begin
        pos_row = 0;
        off_y = 0;
      end else begin
        pos_row++;
      end
    end else begin
      pos_col++;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Driver: a beat moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (in_valid && !in_stall) accumulate_pixel(cur_pixel);
    if (!in_valid || !in_stall) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur_pixel = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_pixel_red <= cur_pixel.red;
        in_pixel_green <= cur_pixel.green;
        in_pixel_blue <= cur_pixel.blue;
        in_frame_start <= cur_pixel.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall generation.
  always @(posedge clk) begin
    tile_avg_t e;
    if (out_valid && !out_stall) begin
      if (tile_avg_q.size() == 0) begin
        report_mismatch("unexpected tile, row", int'(out_tile_row), -1);
      end else begin
        e = tile_avg_q.pop_front();
        if (out_tile_row !== e.tile_row)
          report_mismatch("tile_row", int'(out_tile_row), int'(e.tile_row));
        if (out_tile_column !== e.tile_column)
          report_mismatch("tile_column", int'(out_tile_column), int'(e.tile_column));
        if (out_average_red !== e.avg_red)
          report_mismatch("red", int'(out_average_red), int'(e.avg_red));
        if (out_average_green !== e.avg_green)
          report_mismatch("green", int'(out_average_green), int'(e.avg_green));
        if (out_average_blue !== e.avg_blue)
          report_mismatch("blue", int'(out_average_blue), int'(e.avg_blue));
        if (out_final_tile !== e.final_tile)
          report_mismatch("final_tile", int'(out_final_tile), int'(e.final_tile));
      end
    end
    // One long hold-off during the single-pixel tile phase lets the tile
    // queue fill and back-pressure the input.
    if (phase_no == PRESS_PHASE + 1 && !hold_done && pixel_q.size() > 0) begin
      hold_done = 1'b1;
      hold_cnt = PRESS_CYC;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid || tile_avg_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [mta_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[mta_pkg::CFG_W-1:0];
    case (idx)
      mta_pkg::CFG_TILE_SIZE:    tile_size_reg = val[mta_pkg::TS_CFG_W-1:0];
      mta_pkg::CFG_REGION_WIDTH: region_width_reg = val[mta_pkg::RW_CFG_W-1:0];
      default:                   region_height_reg = val[mta_pkg::RH_CFG_W-1:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Starts a phase: waits for the block to drain, applies settings and idling.
  task automatic start_phase(int ts, int w, int h);
    wait_drained();
    write_reg(mta_pkg::CFG_TILE_SIZE, ts);
    write_reg(mta_pkg::CFG_REGION_WIDTH, w);
    write_reg(mta_pkg::CFG_REGION_HEIGHT, h);
    case (phase_no % 4)
      0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      1: begin sender_idle_pct = 65; receiver_stall_pct = 0; end
      2: begin sender_idle_pct = 0; receiver_stall_pct = 65; end
      default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
    endcase
    phase_no++;
  endtask

  task automatic push_pixel(int r, int g, int b, bit fs);
    pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    p.frame_start = fs;
    pixel_q.insert(pixel_q.size(), p);
    pixels_sent++;
  endtask

  function automatic int rand_chan();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return int'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int ts, w, h, n, budget, cut;
    bit fs;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a handful of pixels in the first tile, no result.
    for (int i = 0; i < 6; i++)
      push_pixel((i % 2) ? 255 : 0, (i % 3) ? 255 : 0, i * 40, i == 0);
    // 2x2 tiles over a 2x2 region: all-white, then all-black via wrap.
    start_phase(2, 2, 2);
    for (int i = 0; i < 4; i++) push_pixel(255, 255, 255, i == 0);
    for (int i = 0; i < 4; i++) push_pixel(0, 0, 0, 1'b0);
    push_pixel(255, 0, 128, 1'b1);
    push_pixel(1, 254, 127, 1'b0);
    // Out-of-range values clamp to the largest tile and region.
    start_phase(127, 4095, 8191);
    for (int i = 0; i < 4; i++) push_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    // Zero values act as one: every pixel is a whole, final tile.
    start_phase(0, 0, 0);
    for (int i = 0; i < 4; i++) push_pixel(i * 85, 255 - i * 85, 170, i == 0);

    while (pixels_sent < 1550) begin
      if (phase_no == PRESS_PHASE) begin
        ts = 1; w = 8; h = 8;
      end else if ($urandom_range(9) == 0) begin
        ts = $urandom_range(1) ? 127 : 100;
        w = $urandom_range(1) ? 4095 : 2048;
        h = int'($urandom_range(8191));
      end else begin
        ts = int'($urandom_range(5));
        w = int'($urandom_range(20));
        h = int'($urandom_range(14));
      end
      start_phase(ts, w, h);
      n = clamp_to(w, MAX_W) * clamp_to(h, mta_pkg::MAX_REGION_HEIGHT);
      budget = 100 + int'($urandom_range(100));
      fs = 1'b1;
      while (budget > 0) begin
        // Mostly whole frames, capped at 150 pixels; some are cut short and restarted.
        cut = ($urandom_range(9) < 2) ? int'($urandom_range(n > 1 ? n - 1 : 1)) : n;
        if (cut > 150) cut = 150;
        for (int i = 0; i < cut; i++)
          push_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0 && fs);
        budget -= cut;
        // After a complete frame the position wraps on its own.
        fs = (cut < n) ? 1'b1 : 1'($urandom_range(1));
      end
    end
    wait_drained();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
